// ----- src/nfba_pkg.sv -----
package nfba_pkg;

    localparam int BLOCKS_DEFAULT    = 16;
    localparam int SIZE_BITS_DEFAULT = 16;

    localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        STATUS_LOADED        = 2'd0,
        STATUS_ALLOCATED     = 2'd1,
        STATUS_NOT_ALLOCATED = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    // per-cell strobes from the controller
    typedef struct packed {
        logic load;
        logic compare;
        logic claim;
    } cell_ctrl_t;

    // priority chain between neighbors: one pass from the rover up, one below it
    typedef struct packed {
        logic seen_hi;
        logic seen_lo;
    } cell_link_t;

    typedef struct packed {
        logic hi;
        logic lo;
    } cell_grant_t;

endpackage

// ----- src/nfba_cell.sv -----
module nfba_cell
    import nfba_pkg::*;
#(
    parameter int BLOCKS    = BLOCKS_DEFAULT,
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT,
    parameter int IDX       = 0
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctrl_t                  ctrl,
    input  logic [SIZE_BITS-1:0]        size_in,
    input  logic [$clog2(BLOCKS):0]     count,
    input  logic [$clog2(BLOCKS)-1:0]   start,
    input  cell_link_t                  link_in,
    output cell_link_t                  link_out,
    output cell_grant_t                 grant
);

    localparam int IDX_W = $clog2(BLOCKS);

    logic [SIZE_BITS-1:0] size_reg;
    logic                 in_use_reg;
    logic                 fit_hi_reg;
    logic                 fit_lo_reg;
    logic                 active;
    logic                 hi;
    logic                 fit;

    assign active = (IDX_W + 1)'(IDX) < count;
    assign hi     = IDX_W'(IDX) >= start;
    assign fit    = !in_use_reg && (size_reg >= size_in) && active;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            size_reg <= size_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            fit_hi_reg <= 1'b0;
            fit_lo_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                in_use_reg <= 1'b0;
            end
            else if (ctrl.claim)
            begin
                in_use_reg <= 1'b1;
            end
            if (ctrl.compare)
            begin
                fit_hi_reg <= fit && hi;
                fit_lo_reg <= fit && !hi;
            end
        end
    end

    // first fitting cell of each pass wins, later ones see the token
    assign grant.hi         = fit_hi_reg && !link_in.seen_hi;
    assign grant.lo         = fit_lo_reg && !link_in.seen_lo;
    assign link_out.seen_hi = link_in.seen_hi || fit_hi_reg;
    assign link_out.seen_lo = link_in.seen_lo || fit_lo_reg;

endmodule

// ----- src/next_fit_block_allocator_top.sv -----
// Next-fit block allocator. A row of BLOCKS cells each holds one block size and its
// in-use flag. A load writes a size and frees that block; a request finds the first
// free block of at least the asked size, starting at the rover and wrapping inside
// the active block count, marks it used and moves the rover past it. Every item
// gives exactly one result. On an accepted request every cell compares its size and
// latches a fit bit; in the resolve step the priority token ripples through the cell
// row, and once the output is free the winner is claimed and the result registered.
// No item is accepted until the last result is registered; a stalled result holds
// the resolve step only once a further item waits. The ripple through all cells is
// the longest path. The user must see that block_count is written only while the block
// is idle; the block itself does not enforce this.
module next_fit_block_allocator_top
    import nfba_pkg::*;
#(
    parameter int BLOCKS    = BLOCKS_DEFAULT,
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        op,
    input  logic [3:0]  block_index,
    input  logic [15:0] size,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [3:0]  granted_block
);

    localparam int IDX_W = $clog2(BLOCKS);
    localparam int CNT_W = IDX_W + 1;
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
    localparam int SEL_W = (IDX_W > 4) ? IDX_W : 4;

    state_t             state_reg, state_next;
    logic [4:0]         block_count_reg;
    logic [IDX_W-1:0]   rover_reg, rover_next;
    logic               op_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    status_t            status_reg, status_next;
    logic [3:0]         granted_reg, granted_next;

    logic               req_fire;
    logic               out_free;
    logic               resolve_fire;
    logic [CW-1:0]      count_ext;
    logic [CW-1:0]      count_clip;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   start;
    logic [SIZE_BITS+15:0] size_ext;
    logic [SIZE_BITS-1:0]  size_m;
    logic [SEL_W-1:0]   load_sel;

    cell_ctrl_t         ctrl    [BLOCKS];
    cell_link_t         links   [BLOCKS+1];
    cell_grant_t        grants  [BLOCKS];
    logic [BLOCKS-1:0]  grant_vec;
    logic [BLOCKS-1:0]  claim_vec;
    logic               any_hi;
    logic               found;
    logic [IDX_W-1:0]   gidx;
    logic [CNT_W-1:0]   gidx_inc;
    logic [IDX_W+3:0]   gidx_ext;

    assign count_ext  = CW'(block_count_reg);
    assign count_clip = (count_ext > CW'(BLOCKS)) ? CW'(BLOCKS) : count_ext;
    assign count      = count_clip[CNT_W-1:0];
    assign start      = ({1'b0, rover_reg} < count) ? rover_reg : '0;
    assign size_ext   = {{SIZE_BITS{1'b0}}, size};
    assign size_m     = size_ext[SIZE_BITS-1:0];
    assign load_sel   = SEL_W'(block_index);

    assign req_fire   = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_stall    = 1'b1;
        resolve_fire = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_RESOLVE:
            begin
                resolve_fire = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign links[0] = '0;

    genvar j;
    generate
        for (j = 0; j < BLOCKS; j++)
        begin : g_cell
            assign ctrl[j].load    = req_fire && !op && (load_sel == SEL_W'(j));
            assign ctrl[j].compare = req_fire && op;
            assign ctrl[j].claim   = claim_vec[j];

            nfba_cell #(
                .BLOCKS    (BLOCKS),
                .SIZE_BITS (SIZE_BITS),
                .IDX       (j)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl[j]),
                .size_in  (size_m),
                .count    (count),
                .start    (start),
                .link_in  (links[j]),
                .link_out (links[j+1]),
                .grant    (grants[j])
            );

            // wrap to the low pass only when nothing fits from the rover up
            assign grant_vec[j] = any_hi ? grants[j].hi : grants[j].lo;
            assign claim_vec[j] = resolve_fire && op_reg && grant_vec[j];
        end
    endgenerate

    assign any_hi = links[BLOCKS].seen_hi;
    assign found  = op_reg && (links[BLOCKS].seen_hi || links[BLOCKS].seen_lo);

    always_comb
    begin
        gidx = '0;
        for (int k = 0; k < BLOCKS; k++)
        begin
            gidx = gidx | (grant_vec[k] ? IDX_W'(k) : '0);
        end
    end

    assign gidx_inc = {1'b0, gidx} + CNT_W'(1);
    assign gidx_ext = {4'b0000, gidx};

    always_comb
    begin
        rover_next     = rover_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (resolve_fire)
        begin
            rsp_valid_next = 1'b1;
            if (!op_reg)
            begin
                status_next  = STATUS_LOADED;
                granted_next = '0;
            end
            else if (found)
            begin
                status_next  = STATUS_ALLOCATED;
                granted_next = gidx_ext[3:0];
                rover_next   = (gidx_inc >= count) ? '0 : gidx_inc[IDX_W-1:0];
            end
            else
            begin
                status_next  = STATUS_NOT_ALLOCATED;
                granted_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= BLOCK_COUNT_RESET;
            rover_reg       <= '0;
            op_reg          <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                block_count_reg <= cfg_data;
            end
            if (req_fire)
            begin
                op_reg <= op;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign granted_block = granted_reg;

`ifndef SYNTHESIS
    a_claim_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(claim_vec))
        else $error("more than one block claimed");

    a_accept_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_RESOLVE) && req_stall)
        else $error("accepted transaction not resolving");

    a_resolve_result: assert property (@(posedge clk) disable iff (!rst_n)
        resolve_fire |=> rsp_valid)
        else $error("resolved transaction produced no result");

    a_rover_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (resolve_fire && found) |=> ({1'b0, rover_reg} < count))
        else $error("rover outside active blocks after grant");
`endif

endmodule

// ----- test/next_fit_block_allocator_top_test.sv -----
module next_fit_block_allocator_top_test;
    import nfba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit OP_LOAD    = 1'b0;
    localparam bit OP_REQUEST = 1'b1;

    localparam int NUM_BLOCKS      = BLOCKS_DEFAULT;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 4;
    localparam int IDLE_LIMIT      = 2000;

    typedef struct packed {
        status_t    st;
        logic [3:0] blk;
    } alloc_result_t;

    typedef struct packed {
        bit         opc;
        logic [3:0] idx;
        logic [15:0] sz;
        bit         typed;
        status_t    st;
        logic [3:0] blk;
    } alloc_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_data;
    logic        req_valid;
    logic        req_stall;
    logic        op;
    logic [3:0]  block_index;
    logic [15:0] size;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [1:0]  status;
    logic [3:0]  granted_block;

    // allocator state as seen from outside
    logic [15:0] block_size_tbl [NUM_BLOCKS];
    bit          block_used [NUM_BLOCKS];
    int          rover_pos;
    logic [4:0]  block_count_cfg;

    alloc_result_t pending_grants [$];
    int  error_count;
    int  burst_left;
    bit  hold_off_req;

    // loads first so no search ever reads an unwritten size
    alloc_row_t alloc_rows [0:24] = '{
        '{OP_LOAD,    4'd0,  16'h0000, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd1,  16'h0001, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd2,  16'h00FF, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd3,  16'h0100, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd4,  16'h1234, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd5,  16'h5555, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd6,  16'hAAAA, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd7,  16'h7FFF, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd8,  16'h8000, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd9,  16'h0010, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd10, 16'h0200, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd11, 16'h0040, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd12, 16'h3000, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd13, 16'h0800, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd14, 16'hFFFE, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd15, 16'hFFFF, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_REQUEST, 4'd0,  16'h0000, 1'b1, STATUS_ALLOCATED,     4'd0},
        '{OP_REQUEST, 4'd7,  16'hFFFF, 1'b1, STATUS_ALLOCATED,     4'd15},
        '{OP_REQUEST, 4'd0,  16'hFFFF, 1'b1, STATUS_NOT_ALLOCATED, 4'd0},
        '{OP_REQUEST, 4'd15, 16'hFFFE, 1'b1, STATUS_ALLOCATED,     4'd14},
        // reload of a used block frees it
        '{OP_LOAD,    4'd15, 16'hFFFF, 1'b1, STATUS_LOADED,        4'd0},
        '{OP_REQUEST, 4'd0,  16'h0001, 1'b0, STATUS_LOADED,        4'd0},
        '{OP_REQUEST, 4'd0,  16'h1000, 1'b0, STATUS_LOADED,        4'd0},
        '{OP_REQUEST, 4'd0,  16'h0100, 1'b0, STATUS_LOADED,        4'd0},
        '{OP_LOAD,    4'd0,  16'h0000, 1'b1, STATUS_LOADED,        4'd0}
    };

    next_fit_block_allocator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .op            (op),
        .block_index   (block_index),
        .size          (size),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .granted_block (granted_block)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic alloc_result_t predict_alloc(bit opc, logic [3:0] idx,
                                                    logic [15:0] sz);
        alloc_result_t r;
        int active;
        int first;
        int j;
        r.st  = STATUS_LOADED;
        r.blk = 4'd0;
        if (opc == OP_LOAD)
        begin
            block_size_tbl[idx] = sz;
            block_used[idx]     = 1'b0;
            return r;
        end
        active = (block_count_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count_cfg);
        first  = (rover_pos < active) ? rover_pos : 0;
        r.st   = STATUS_NOT_ALLOCATED;
        for (int k = 0; k < active; k++)
        begin
            j = first + k;
            if (j >= active)
                j -= active;
            if (!block_used[j] && block_size_tbl[j] >= sz)
            begin
                block_used[j] = 1'b1;
                rover_pos     = (j + 1 >= active) ? 0 : j + 1;
                r.st          = STATUS_ALLOCATED;
                r.blk         = 4'(j);
                return r;
            end
        end
        return r;
    endfunction

    task automatic send_txn(bit opc, logic [3:0] idx, logic [15:0] sz, bit typed,
                            status_t fixed_st, logic [3:0] fixed_blk);
        alloc_result_t r;
        req_valid   <= 1'b1;
        op          <= opc;
        block_index <= idx;
        size        <= sz;
        do
            @(posedge clk);
        while (req_stall);
        r = predict_alloc(opc, idx, sz);
        if (typed)
        begin
            r.st  = fixed_st;
            r.blk = fixed_blk;
        end
        pending_grants.push_back(r);
    endtask

    // bursts of back-to-back transactions separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_block_count(logic [4:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we          <= 1'b0;
        block_count_cfg  = value;
        burst_left       = 0;
    endtask

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial
    begin
        int mode;
        int run_len;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                mode    = $urandom_range(0, 2);
                run_len = $urandom_range(1, 40);
                for (int i = 0; i < run_len; i++)
                begin
                    case (mode)
                        0: rsp_stall <= 1'b0;
                        1: rsp_stall <= 1'($urandom_range(0, 1));
                        default: rsp_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                    if (hold_off_req)
                        break;
                end
            end
        end
    end

    // result checker
    initial
    begin
        alloc_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_grants.size() == 0)
                begin
                    $display("%0t: unexpected transaction, status %0d block %0d",
                             $time, status, granted_block);
                    error_count++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.st, status);
                        error_count++;
                    end
                    if (granted_block !== want.blk)
                    begin
                        $display("%0t: granted_block mismatch, expected %0d actual %0d",
                                 $time, want.blk, granted_block);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("next_fit_block_allocator_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int          n_items;
        int          pick;
        logic [4:0]  cnt;
        logic [3:0]  idx;
        logic [15:0] sz;
        bit          opc;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = 5'd0;
        req_valid   = 1'b0;
        op          = OP_LOAD;
        block_index = 4'd0;
        size        = 16'd0;
        error_count = 0;
        burst_left  = 0;
        hold_off_req = 1'b0;
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            block_size_tbl[b] = 16'd0;
            block_used[b]     = 1'b0;
        end
        rover_pos       = 0;
        block_count_cfg = BLOCK_COUNT_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_block_count(5'd16);
        foreach (alloc_rows[r])
        begin
            pace_sender();
            send_txn(alloc_rows[r].opc, alloc_rows[r].idx, alloc_rows[r].sz,
                     alloc_rows[r].typed, alloc_rows[r].st, alloc_rows[r].blk);
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: cnt = 5'd0;
                1: cnt = 5'd31;
                2: cnt = 5'd1;
                3: cnt = 5'd16;
                4: cnt = 5'd17;
                default: cnt = 5'($urandom_range(1, 16));
            endcase
            write_block_count(cnt);
            n_items = (ph == 0) ? 15 : 65;
            // long receiver hold-off so the block backs up into the request side
            if (ph == 3)
                hold_off_req = 1'b1;
            for (int i = 0; i < n_items; i++)
            begin
                opc = ($urandom_range(0, 9) < 6) ? OP_REQUEST : OP_LOAD;
                idx = 4'($urandom_range(0, NUM_BLOCKS - 1));
                pick = $urandom_range(0, 9);
                if (opc == OP_REQUEST)
                begin
                    if (pick < 6)
                    begin
                        sz = block_size_tbl[$urandom_range(0, NUM_BLOCKS - 1)];
                        if (sz > 16'd3 && $urandom_range(0, 1))
                            sz = sz - 16'($urandom_range(0, 3));
                    end
                    else if (pick < 8)
                        sz = 16'($urandom_range(0, 1023));
                    else if (pick == 8)
                        sz = 16'($urandom);
                    else
                        sz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                else
                begin
                    if (pick < 6)
                        sz = 16'($urandom_range(0, 1023));
                    else if (pick < 9)
                        sz = 16'($urandom);
                    else
                        sz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                pace_sender();
                send_txn(opc, idx, sz, 1'b0, STATUS_LOADED, 4'd0);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("next_fit_block_allocator_top verification clean");
        else
            $display("next_fit_block_allocator_top verification failed");
        $finish;
    end

endmodule

// ----- next_fit_block_allocator_top.f -----
src/nfba_pkg.sv
src/nfba_cell.sv
src/next_fit_block_allocator_top.sv
test/next_fit_block_allocator_top_test.sv
